// ===== rtl/nrc_pkg.sv =====
package nrc_pkg;

  localparam logic [31:0] REC_MAGIC   = 32'h5445_4E41;
  localparam logic [31:0] REC_VERSION = 32'd2;
  localparam logic [31:0] CRC_POLY    = 32'hEDB8_8320;
  localparam logic [31:0] CRC_INIT    = 32'hFFFF_FFFF;
  localparam logic [7:0]  OCTET_LOOP  = 8'd127;
  localparam logic [7:0]  OCTET_MCAST = 8'd224;

  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_BAD_MAGIC   = 3'd1;
  localparam logic [2:0] ST_BAD_VERSION = 3'd2;
  localparam logic [2:0] ST_BAD_CRC     = 3'd3;
  localparam logic [2:0] ST_BAD_FIELDS  = 3'd4;

  localparam logic [2:0] W_MAGIC   = 3'd0;
  localparam logic [2:0] W_VERSION = 3'd1;
  localparam logic [2:0] W_ADDR    = 3'd2;
  localparam logic [2:0] W_MASK    = 3'd3;
  localparam logic [2:0] W_GATEWAY = 3'd4;
  localparam logic [2:0] W_PORT    = 3'd5;
  localparam logic [2:0] W_CRC     = 3'd6;
  localparam logic [2:0] W_LAST    = 3'd7;

  typedef struct packed {
    logic [31:0] record_word;
    logic        first_word;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] ip_addr;
    logic [31:0] net_mask;
    logic [31:0] gateway_addr;
    logic [15:0] listen_port;
  } out_item_t;

  typedef struct packed {
    logic magic_ok;
    logic version_ok;
    logic crc_ok;
  } chk_flags_t;

endpackage

// ===== rtl/nrc_crc.sv =====
module nrc_crc (
  input  logic [31:0] crc_in,
  input  logic [31:0] word_in,
  output logic [31:0] crc_out
);
  import nrc_pkg::*;

  logic [31:0] x;
  logic [31:0] c;

  assign x = crc_in ^ word_in;

  // Thirty-two register shifts with zero data; the unrolled steps reduce to an XOR network.
  always_comb begin
    c = x;
    for (int s = 0; s < 32; s++) begin
      c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
    end
  end

  assign crc_out = c;

endmodule

// ===== rtl/nrc_eval.sv =====
module nrc_eval (
  input  nrc_pkg::chk_flags_t flags,
  input  logic [31:0]         held_ip,
  input  logic [31:0]         held_mask,
  input  logic [31:0]         held_gateway,
  input  logic [15:0]         held_port,
  output nrc_pkg::out_item_t  result
);
  import nrc_pkg::*;

  logic [31:0] mask_inv;
  logic [31:0] mask_inc;
  logic        ip_ok;
  logic        gw_ok;
  logic        mask_ok;
  logic        fields_ok;

  assign ip_ok = (held_ip[31:24] != 8'd0) && (held_ip[31:24] != OCTET_LOOP) &&
                 (held_ip[31:24] < OCTET_MCAST);
  assign gw_ok = (held_gateway[31:24] != 8'd0) && (held_gateway[31:24] != OCTET_LOOP) &&
                 (held_gateway[31:24] < OCTET_MCAST);

  // A contiguous mask inverts to a run of low ones, so adding one clears every set bit.
  assign mask_inv  = ~held_mask;
  assign mask_inc  = mask_inv + 32'd1;
  assign mask_ok   = (held_mask != 32'd0) && (held_mask != CRC_INIT) &&
                     ((mask_inv & mask_inc) == 32'd0);
  assign fields_ok = ip_ok && gw_ok && mask_ok && (held_port != 16'd0);

  always_comb begin
    result.status       = ST_OK;
    result.ip_addr      = held_ip;
    result.net_mask     = held_mask;
    result.gateway_addr = held_gateway;
    result.listen_port  = held_port;
    if (!flags.magic_ok) begin
      result.status = ST_BAD_MAGIC;
    end else if (!flags.version_ok) begin
      result.status = ST_BAD_VERSION;
    end else if (!flags.crc_ok) begin
      result.status = ST_BAD_CRC;
    end else if (!fields_ok) begin
      result.status = ST_BAD_FIELDS;
    end
    if (!flags.magic_ok || !flags.version_ok || !flags.crc_ok) begin
      result.ip_addr      = 32'd0;
      result.net_mask     = 32'd0;
      result.gateway_addr = 32'd0;
      result.listen_port  = 16'd0;
    end
  end

endmodule

// ===== rtl/net_record_checker.sv =====
// Channel  Direction  Handshake             Payload
// in       input      in_valid / in_stall   in_data (one record word)
// out      output     out_valid / out_stall out_data (status and unpacked fields)
//
// Each word is taken into an input register, then processed: a parallel
// CRC-32 update over the 32 bits of the word and the header checks.
// One word can be accepted every cycle unless a closing word waits for a stalled
// result; a result is loaded into the output register as its last word leaves the input register.
// Reset (synchronous, rst_n low) empties both registers and restarts at word 0.
// A stalled result holds only words that end a record; other words keep flowing.
module net_record_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  nrc_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output nrc_pkg::out_item_t  out_data
);
  import nrc_pkg::*;

  in_item_t    in_r;
  logic        in_vld_r;
  logic        in_vld_nxt;
  out_item_t   out_r;
  logic        out_vld_r;
  logic        out_vld_nxt;
  logic [2:0]  word_count_r;
  logic [31:0] crc_r;
  chk_flags_t  flags_r;
  logic [31:0] held_ip_r;
  logic [31:0] held_mask_r;
  logic [31:0] held_gateway_r;
  logic [15:0] held_port_r;

  logic [2:0]  idx;
  logic        is_last;
  logic        out_free;
  logic        s1_adv;
  logic        in_acc;
  logic [31:0] crc_base;
  logic [31:0] crc_new;
  out_item_t   result;

  assign idx      = in_r.first_word ? W_MAGIC : word_count_r;
  assign is_last  = (idx == W_LAST);
  assign out_free = !out_vld_r || !out_stall;
  assign s1_adv   = in_vld_r && (!is_last || out_free);
  assign in_stall = in_vld_r && !s1_adv;
  assign in_acc   = in_valid && !in_stall;
  assign crc_base = (idx == W_MAGIC) ? CRC_INIT : crc_r;

  assign in_vld_nxt  = in_acc || (in_vld_r && !s1_adv);
  assign out_vld_nxt = (s1_adv && is_last) || (out_vld_r && out_stall);

  nrc_crc u_crc (
    .crc_in  (crc_base),
    .word_in (in_r.record_word),
    .crc_out (crc_new)
  );

  nrc_eval u_eval (
    .flags        (flags_r),
    .held_ip      (held_ip_r),
    .held_mask    (held_mask_r),
    .held_gateway (held_gateway_r),
    .held_port    (held_port_r),
    .result       (result)
  );

  always_ff @(posedge clk) begin
    if (in_acc) begin
      in_r <= in_data;
    end
    if (s1_adv && is_last) begin
      out_r <= result;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r       <= 1'b0;
      out_vld_r      <= 1'b0;
      word_count_r   <= W_MAGIC;
      crc_r          <= CRC_INIT;
      flags_r        <= '0;
      held_ip_r      <= 32'd0;
      held_mask_r    <= 32'd0;
      held_gateway_r <= 32'd0;
      held_port_r    <= 16'd0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
      if (s1_adv) begin
        word_count_r <= idx + 3'd1;
        if (idx <= W_PORT) begin
          crc_r <= crc_new;
        end
        case (idx)
          W_MAGIC:   flags_r.magic_ok   <= (in_r.record_word == REC_MAGIC);
          W_VERSION: flags_r.version_ok <= (in_r.record_word == REC_VERSION);
          W_ADDR:    held_ip_r          <= in_r.record_word;
          W_MASK:    held_mask_r        <= in_r.record_word;
          W_GATEWAY: held_gateway_r     <= in_r.record_word;
          W_PORT:    held_port_r        <= in_r.record_word[15:0];
          W_CRC:     flags_r.crc_ok     <= (in_r.record_word == ~crc_r);
          default: begin
          end
        endcase
      end
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

`ifndef SYNTHESIS
  a_stall_only_on_full_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (in_vld_r && is_last && out_vld_r && out_stall))
    else $error("input stalled while the result register could load");

  a_last_word_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && is_last) |=> out_vld_r)
    else $error("closing word did not produce a result");

  a_count_holds_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_adv |=> $stable(word_count_r))
    else $error("word count moved without a processed word");

  a_header_fail_zeroes: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && (out_r.status == ST_BAD_MAGIC || out_r.status == ST_BAD_VERSION ||
                   out_r.status == ST_BAD_CRC))
      |-> (out_r.ip_addr == 32'd0 && out_r.net_mask == 32'd0 &&
           out_r.gateway_addr == 32'd0 && out_r.listen_port == 16'd0))
    else $error("header failure result carries field values");
`endif

endmodule

// ===== sim/net_record_checker_tb.sv =====
`timescale 1ns / 1ps

module net_record_checker_tb;
  import nrc_pkg::*;

  localparam int HOLD_CYCLES  = 300;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 20;
  localparam int MAX_REPORTS  = 10;

  typedef enum int {
    KIND_GOOD,
    KIND_BAD_FIELDS,
    KIND_BAD_CRC,
    KIND_BAD_VERSION,
    KIND_BAD_MAGIC,
    KIND_CUT,
    KIND_NOISE
  } record_kind_e;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  in_item_t  pending_words[$];
  out_item_t expected_verdicts[$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_req_id = 0;
  int hold_seen_id = 0;
  int hold_left = 0;
  int mismatch_count = 0;
  int cycle_count = 0;
  int items_queued = 0;

  logic [31:0] rec_words[8];
  logic [2:0]  gen_pos = W_MAGIC;

  logic [2:0]  rec_pos = W_MAGIC;
  logic [31:0] run_crc = CRC_INIT;
  logic        magic_seen = 1'b0;
  logic        version_seen = 1'b0;
  logic        crc_seen = 1'b0;
  logic [31:0] kept_ip = '0;
  logic [31:0] kept_mask = '0;
  logic [31:0] kept_gateway = '0;
  logic [15:0] kept_port = '0;

  net_record_checker u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Reflected CRC-32 over one word, low bit first.
  function automatic logic [31:0] crc32_fold_word(input logic [31:0] crc,
                                                  input logic [31:0] w);
    logic fb;
    for (int b = 0; b < 32; b++) begin
      fb = crc[0] ^ w[b];
      crc = crc >> 1;
      if (fb) crc = crc ^ CRC_POLY;
    end
    return crc;
  endfunction

  function automatic logic host_valid(input logic [31:0] a);
    return a[31:24] != 8'd0 && a[31:24] != OCTET_LOOP && a[31:24] < OCTET_MCAST;
  endfunction

  function automatic logic mask_valid(input logic [31:0] m);
    logic [31:0] inv;
    inv = ~m;
    return m != 32'd0 && m != 32'hFFFF_FFFF && (inv & (inv + 32'd1)) == 32'd0;
  endfunction

  task automatic track_record_word(input in_item_t it);
    logic [2:0] pos;
    out_item_t  res;
    pos = it.first_word ? W_MAGIC : rec_pos;
    if (pos == W_MAGIC) run_crc = CRC_INIT;
    case (pos)
      W_MAGIC:   magic_seen = (it.record_word == REC_MAGIC);
      W_VERSION: version_seen = (it.record_word == REC_VERSION);
      W_ADDR:    kept_ip = it.record_word;
      W_MASK:    kept_mask = it.record_word;
      W_GATEWAY: kept_gateway = it.record_word;
      W_PORT:    kept_port = it.record_word[15:0];
      W_CRC:     crc_seen = (it.record_word == ~run_crc);
      default: begin
        if (!magic_seen) res.status = ST_BAD_MAGIC;
        else if (!version_seen) res.status = ST_BAD_VERSION;
        else if (!crc_seen) res.status = ST_BAD_CRC;
        else if (!host_valid(kept_ip) || !mask_valid(kept_mask) ||
                 !host_valid(kept_gateway) || kept_port == 16'd0) res.status = ST_BAD_FIELDS;
        else res.status = ST_OK;
        if (res.status == ST_OK || res.status == ST_BAD_FIELDS) begin
          res.ip_addr = kept_ip;
          res.net_mask = kept_mask;
          res.gateway_addr = kept_gateway;
          res.listen_port = kept_port;
        end else begin
          res.ip_addr = '0;
          res.net_mask = '0;
          res.gateway_addr = '0;
          res.listen_port = '0;
        end
        expected_verdicts.push_back(res);
      end
    endcase
    if (pos <= W_PORT) run_crc = crc32_fold_word(run_crc, it.record_word);
    rec_pos = pos + 3'd1;
  endtask

  task automatic check_verdict(input out_item_t got);
    out_item_t want;
    if (expected_verdicts.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
        $display("unexpected result: status=%0d ip=%h mask=%h gw=%h port=%h",
                 got.status, got.ip_addr, got.net_mask, got.gateway_addr, got.listen_port);
    end else begin
      want = expected_verdicts.pop_front();
      if (got.status !== want.status || got.ip_addr !== want.ip_addr ||
          got.net_mask !== want.net_mask || got.gateway_addr !== want.gateway_addr ||
          got.listen_port !== want.listen_port) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
          $display("mismatch: expected status=%0d ip=%h mask=%h gw=%h port=%h",
                   want.status, want.ip_addr, want.net_mask, want.gateway_addr,
                   want.listen_port);
          $display("          actual   status=%0d ip=%h mask=%h gw=%h port=%h",
                   got.status, got.ip_addr, got.net_mask, got.gateway_addr, got.listen_port);
        end
      end
    end
  endtask

  function automatic logic [31:0] random_host();
    logic [7:0] top;
    top = 8'($urandom_range(1, 223));
    if (top == OCTET_LOOP) top = 8'd1;
    return {top, 24'($urandom)};
  endfunction

  task automatic seal_record();
    logic [31:0] c;
    c = CRC_INIT;
    for (int i = 0; i < 6; i++) c = crc32_fold_word(c, rec_words[i]);
    rec_words[W_CRC] = ~c;
  endtask

  task automatic make_record(input record_kind_e kind);
    logic [31:0] good_mask;
    int          len;
    len = $urandom_range(1, 31);
    good_mask = 32'hFFFF_FFFF << (32 - len);
    rec_words[W_MAGIC] = REC_MAGIC;
    rec_words[W_VERSION] = REC_VERSION;
    rec_words[W_ADDR] = random_host();
    rec_words[W_MASK] = good_mask;
    rec_words[W_GATEWAY] = random_host();
    rec_words[W_PORT] = {16'($urandom), 16'($urandom_range(1, 65535))};
    rec_words[W_LAST] = $urandom;
    case (kind)
      KIND_BAD_MAGIC: begin
        rec_words[W_MAGIC] = $urandom_range(1) ? REC_MAGIC ^ (32'd1 << $urandom_range(31))
                                               : 32'($urandom);
        if ($urandom_range(1)) rec_words[W_VERSION] = $urandom;
      end
      KIND_BAD_VERSION: begin
        rec_words[W_VERSION] = $urandom_range(1) ? 32'($urandom_range(3)) : 32'($urandom);
      end
      KIND_BAD_FIELDS: begin
        case ($urandom_range(8))
          0: rec_words[W_ADDR][31:24] = 8'd0;
          1: rec_words[W_ADDR][31:24] = OCTET_LOOP;
          2: rec_words[W_ADDR][31:24] = 8'($urandom_range(224, 255));
          3: rec_words[W_MASK] = 32'd0;
          4: rec_words[W_MASK] = 32'hFFFF_FFFF;
          5: rec_words[W_MASK] = good_mask | 32'd1;
          6: rec_words[W_MASK] = good_mask & 32'h7FFF_FFFF;
          7: rec_words[W_GATEWAY][31:24] = $urandom_range(1) ? 8'd0
                                                              : 8'($urandom_range(224, 255));
          default: rec_words[W_PORT][15:0] = 16'd0;
        endcase
      end
      default: ;
    endcase
    seal_record();
    if (kind == KIND_BAD_CRC) rec_words[W_CRC] ^= 32'd1 << $urandom_range(31);
  endtask

  task automatic push_word(input logic [31:0] w, input logic f);
    in_item_t it;
    it.record_word = w;
    it.first_word = f;
    pending_words.push_back(it);
    gen_pos = f ? 3'd1 : gen_pos + 3'd1;
    items_queued++;
  endtask

  // A record that does not start on a record boundary of the block gets a first mark.
  task automatic queue_record(input logic mark, input int count);
    for (int i = 0; i < count; i++)
      push_word(rec_words[i], i == 0 ? (mark || gen_pos != W_MAGIC) : 1'b0);
  endtask

  task automatic wait_drained();
    while (pending_words.size() != 0 || in_valid || expected_verdicts.size() != 0)
      @(negedge clk);
  endtask

  task automatic run_phase(input int send_pct, input int recv_pct, input int n_items,
                           input bit with_hold);
    int start;
    int pick;
    int n;
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
    if (with_hold) hold_req_id++;
    start = items_queued;
    while (items_queued - start < n_items) begin
      pick = $urandom_range(99);
      if (pick < 40) begin
        make_record(KIND_GOOD);
        queue_record(1'($urandom_range(1)), 8);
      end else if (pick < 52) begin
        make_record(KIND_BAD_FIELDS);
        queue_record(1'($urandom_range(1)), 8);
      end else if (pick < 62) begin
        make_record(KIND_BAD_CRC);
        queue_record(1'($urandom_range(1)), 8);
      end else if (pick < 71) begin
        make_record(KIND_BAD_VERSION);
        queue_record(1'($urandom_range(1)), 8);
      end else if (pick < 80) begin
        make_record(KIND_BAD_MAGIC);
        queue_record(1'($urandom_range(1)), 8);
      end else if (pick < 90) begin
        make_record(KIND_GOOD);
        queue_record(1'b1, $urandom_range(1, 7));
      end else begin
        n = $urandom_range(1, 5);
        for (int i = 0; i < n; i++) push_word($urandom, $urandom_range(7) == 0);
      end
    end
    wait_drained();
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) track_record_word(in_data);
      if (!in_valid || !in_stall) begin
        if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_data <= pending_words.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) check_verdict(out_data);
      if (hold_seen_id != hold_req_id) begin
        hold_seen_id <= hold_req_id;
        hold_left <= HOLD_CYCLES;
        out_stall <= 1'b1;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // The first record after reset carries no first mark.
    make_record(KIND_GOOD);
    rec_words[W_ADDR][31:24] = 8'd223;
    rec_words[W_PORT] = 32'hFFFF_FFFF;
    rec_words[W_LAST] = 32'hFFFF_FFFF;
    seal_record();
    queue_record(1'b0, 8);
    make_record(KIND_GOOD);
    queue_record(1'b1, 2);
    make_record(KIND_GOOD);
    rec_words[W_MASK] = 32'hFFFF_FFFF;
    rec_words[W_PORT] = 32'hFFFF_0000;
    rec_words[W_LAST] = 32'd0;
    seal_record();
    queue_record(1'b1, 8);
    make_record(KIND_BAD_MAGIC);
    rec_words[W_MAGIC] = 32'd0;
    seal_record();
    queue_record(1'b0, 8);
    send_idle_pct = 30;
    recv_stall_pct = 30;
    wait_drained();

    run_phase(0, 0, 190, 1'b1);
    run_phase(84, 0, 190, 1'b0);
    run_phase(0, 84, 190, 1'b0);
    run_phase(38, 38, 190, 1'b0);

    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatch_count == 0 && expected_verdicts.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== net_record_checker.f =====
rtl/nrc_pkg.sv
rtl/nrc_crc.sv
rtl/nrc_eval.sv
rtl/net_record_checker.sv
sim/net_record_checker_tb.sv
